// ===== sv/rgb_to_hsl_converter_defines.svh =====
// Assertion macros shared by the color converter RTL.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RHC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RHC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/rhc_pkg.sv =====
package rhc_pkg;

    localparam int CH_W    = 8;
    localparam int SUM_W   = CH_W + 1;
    // Hue numerator stays below six times the largest channel difference.
    localparam int NUM_W   = 11;
    localparam int DEN_W   = 11;
    localparam int OUT_W   = 16;
    localparam int OFF_W   = 3;
    localparam int LANES   = 2;

    localparam int DEF_FRACTION_BITS = 16;

    // Lightness multiplies by a reciprocal and drops this many low bits.
    localparam int LIGHT_SHIFT = 18;

    localparam int LANE_HUE   = 0;
    localparam int LANE_SAT   = 1;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0] t_den;
    typedef logic [OFF_W-1:0] t_off;
    typedef logic [OUT_W-1:0] t_field;

    localparam t_chan CH_MAX      = t_chan'(255);
    localparam t_sum  SUM_MAX     = t_sum'(510);
    localparam t_num  HUE_SECTORS = t_num'(6);

    localparam t_off OFF_RED      = t_off'(0);
    localparam t_off OFF_GREEN    = t_off'(2);
    localparam t_off OFF_BLUE     = t_off'(4);
    localparam t_off OFF_RED_WRAP = t_off'(6);

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef struct packed {
        t_field hue;
        t_field saturation;
        t_field lightness;
    } t_hsl;

    typedef struct packed {
        t_num num;
        t_den den;
    } t_div_op;

endpackage

// ===== sv/rhc_stream_if.sv =====
interface rhc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== sv/rhc_divpipe.sv =====
`include "rgb_to_hsl_converter_defines.svh"

// Restoring dividers side by side, one per lane, one quotient bit per stage.
// Each lane divides num * (2^FRACTION_BITS - 1) by den; the caller keeps
// num <= den and den > 0, so the quotient fits in FRACTION_BITS bits.
// The side value rides along with each item unchanged.
module rhc_divpipe #(
    parameter int FRACTION_BITS = rhc_pkg::DEF_FRACTION_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  rhc_pkg::t_div_op [rhc_pkg::LANES-1:0]             i_ops,
    input  logic [FRACTION_BITS-1:0]                          i_side,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic [rhc_pkg::LANES-1:0][FRACTION_BITS-1:0]      o_quot,
    output logic [FRACTION_BITS-1:0]                          o_side
);
    localparam int NW = rhc_pkg::NUM_W;
    localparam int DW = rhc_pkg::DEN_W;
    localparam int FB = FRACTION_BITS;
    localparam int XW = NW + FB;
    localparam int LN = rhc_pkg::LANES;

    logic [DW-1:0] r_rem [0:FB][0:LN-1];
    logic [FB-1:0] r_low [0:FB][0:LN-1];
    logic [FB-1:0] r_q   [0:FB][0:LN-1];
    logic [DW-1:0] r_div [0:FB][0:LN-1];
    logic [DW-1:0] n_rem [0:FB][0:LN-1];
    logic [FB-1:0] n_low [0:FB][0:LN-1];
    logic [FB-1:0] n_q   [0:FB][0:LN-1];
    logic [DW-1:0] n_div [0:FB][0:LN-1];
    logic [FB-1:0] r_side [0:FB];
    logic [FB:0]   r_valid;
    logic [FB:0]   w_en;

    // A stage may load when some stage from it to the output is empty,
    // or when the output item is being taken.
    for (genvar j = 0; j <= FB; j++) begin : g_en
        assign w_en[j] = i_ready || !(&r_valid[FB:j]);
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[FB];

    always_comb begin
        logic [XW-1:0] v_x;
        logic [DW:0]   v_t;
        logic [DW:0]   v_r;
        logic          v_ge;
        for (int l = 0; l < LN; l++) begin
            // num * (2^FB - 1) as a shift and one subtract.
            v_x = {i_ops[l].num, {FB{1'b0}}} - XW'(i_ops[l].num);
            n_rem[0][l] = DW'(v_x[XW-1 -: NW]);
            n_low[0][l] = v_x[FB-1:0];
            n_q[0][l]   = '0;
            n_div[0][l] = i_ops[l].den;
        end
        for (int j = 1; j <= FB; j++) begin
            for (int l = 0; l < LN; l++) begin
                v_t  = {r_rem[j-1][l], r_low[j-1][l][FB-1]};
                v_ge = (v_t >= {1'b0, r_div[j-1][l]});
                v_r  = v_ge ? (v_t - {1'b0, r_div[j-1][l]}) : v_t;
                n_rem[j][l] = v_r[DW-1:0];
                n_low[j][l] = {r_low[j-1][l][FB-2:0], 1'b0};
                n_q[j][l]   = {r_q[j-1][l][FB-2:0], v_ge};
                n_div[j][l] = r_div[j-1][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int j = 1; j <= FB; j++) begin
                if (w_en[j]) begin
                    r_valid[j] <= r_valid[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= FB; j++) begin
            if (w_en[j]) begin
                for (int l = 0; l < LN; l++) begin
                    r_rem[j][l] <= n_rem[j][l];
                    r_low[j][l] <= n_low[j][l];
                    r_q[j][l]   <= n_q[j][l];
                    r_div[j][l] <= n_div[j][l];
                end
            end
        end
        if (w_en[0]) begin
            r_side[0] <= i_side;
        end
        for (int j = 1; j <= FB; j++) begin
            if (w_en[j]) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    for (genvar l = 0; l < LN; l++) begin : g_out
        assign o_quot[l] = r_q[FB][l];
    end

    assign o_side = r_side[FB];

    for (genvar l = 0; l < LN; l++) begin : g_chk
        `RHC_ASSERT_IMPLIES(a_rem_below_div, i_clk, i_rst_n, r_valid[FB], r_rem[FB][l] < r_div[FB][l], "division remainder is not below its divisor")
    end

    `RHC_ASSERT_IMPLIES(a_refuse_only_when_full, i_clk, i_rst_n, !o_ready, &r_valid, "divider refused an item with an empty stage")

    `RHC_ASSERT_NEXT(a_stall_keeps_result, i_clk, i_rst_n, r_valid[FB] && !i_ready, r_valid[FB] && $stable(o_quot), "stalled quotient changed or was dropped")

endmodule

// ===== sv/rgb_to_hsl_converter.sv =====
// RGB to HSL pixel converter.
// i_pix (sink) carries one 8-bit red, green, blue pixel per item; o_hsl
// (source) returns hue, saturation and lightness as 16-bit fractions of
// 2^FRACTION_BITS - 1, truncated. Both sides use valid/ready and an item
// moves at a rising edge with valid and ready high.
// The pipeline: two stages find max, min, sector, the divider operands and
// the lightness (a constant reciprocal multiply), one stage forms the scaled
// dividends, and one restoring divider stage per quotient bit runs the hue
// and saturation divisions in parallel while the lightness rides along.
// Throughput: one pixel per clock, sustained while o_hsl takes each result.
// When o_hsl stalls, the finished item stays on the output register and
// earlier stages keep filling any empty slots, so i_pix.ready only drops
// once every stage holds an item. Nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline; no pixel is
// pending afterwards and i_pix.ready is high.
`include "rgb_to_hsl_converter_defines.svh"

module rgb_to_hsl_converter #(
    parameter int FRACTION_BITS = rhc_pkg::DEF_FRACTION_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rhc_stream_if.sink   i_pix,
    rhc_stream_if.source o_hsl
);
    localparam int LN  = rhc_pkg::LANES;
    localparam int LW  = FRACTION_BITS + rhc_pkg::LIGHT_SHIFT - rhc_pkg::CH_W;
    localparam int LPW = rhc_pkg::SUM_W + LW;
    // Reciprocal of 510 at the output scale, rounded up. For every sum up to
    // 510 the shifted product floors to exactly sum * (2^FRACTION_BITS - 1) / 510.
    localparam logic [LW-1:0] LIGHT_MUL = LW'(
        (((64'd1 << FRACTION_BITS) - 64'd1) * (64'd1 << rhc_pkg::LIGHT_SHIFT)
         + 64'(rhc_pkg::SUM_MAX) - 64'd1) / 64'(rhc_pkg::SUM_MAX));

    // Stage 1: extremes and sector.
    logic             r_v1;
    rhc_pkg::t_chan   r_hi1;
    rhc_pkg::t_chan   r_lo1;
    logic [rhc_pkg::CH_W:0] r_num1;
    rhc_pkg::t_off    r_off1;
    rhc_pkg::t_chan   n_hi1;
    rhc_pkg::t_chan   n_lo1;
    logic [rhc_pkg::CH_W:0] n_num1;
    rhc_pkg::t_off    n_off1;
    rhc_pkg::t_sector w_sec;

    // Stage 2: divider operands and lightness.
    logic                                 r_v2;
    rhc_pkg::t_div_op [LN-1:0]            r_op2;
    rhc_pkg::t_div_op [LN-1:0]            n_op2;
    logic [FRACTION_BITS-1:0]             r_light2;
    logic [FRACTION_BITS-1:0]             n_light2;

    logic                                 w_en1;
    logic                                 w_en2;
    logic                                 w_div_ready;
    logic                                 w_div_valid;
    logic [LN-1:0][FRACTION_BITS-1:0]     w_quot;
    logic [FRACTION_BITS-1:0]             w_light;

    assign w_en2       = !r_v2 || w_div_ready;
    assign w_en1       = !r_v1 || w_en2;
    assign i_pix.ready = w_en1;

    always_comb begin
        rhc_pkg::t_chan v_r;
        rhc_pkg::t_chan v_g;
        rhc_pkg::t_chan v_b;
        v_r = i_pix.data.red;
        v_g = i_pix.data.green;
        v_b = i_pix.data.blue;

        // Red wins ties, then green.
        if (v_r >= v_g && v_r >= v_b) begin
            w_sec = rhc_pkg::SEC_RED;
        end else if (v_g >= v_b) begin
            w_sec = rhc_pkg::SEC_GREEN;
        end else begin
            w_sec = rhc_pkg::SEC_BLUE;
        end

        n_lo1 = v_r;
        if (v_g < n_lo1) begin
            n_lo1 = v_g;
        end
        if (v_b < n_lo1) begin
            n_lo1 = v_b;
        end

        n_hi1  = v_b;
        n_num1 = {1'b0, v_r} - {1'b0, v_g};
        n_off1 = rhc_pkg::OFF_BLUE;
        unique case (w_sec)
            rhc_pkg::SEC_RED: begin
                n_hi1  = v_r;
                n_num1 = {1'b0, v_g} - {1'b0, v_b};
                n_off1 = (v_g < v_b) ? rhc_pkg::OFF_RED_WRAP : rhc_pkg::OFF_RED;
            end
            rhc_pkg::SEC_GREEN: begin
                n_hi1  = v_g;
                n_num1 = {1'b0, v_b} - {1'b0, v_r};
                n_off1 = rhc_pkg::OFF_GREEN;
            end
            rhc_pkg::SEC_BLUE: begin
                n_hi1  = v_b;
                n_num1 = {1'b0, v_r} - {1'b0, v_g};
                n_off1 = rhc_pkg::OFF_BLUE;
            end
            default: begin
                n_hi1  = v_b;
                n_num1 = {1'b0, v_r} - {1'b0, v_g};
                n_off1 = rhc_pkg::OFF_BLUE;
            end
        endcase
    end

    always_comb begin
        rhc_pkg::t_sum  v_sum;
        rhc_pkg::t_chan v_d;
        rhc_pkg::t_sum  v_den;
        rhc_pkg::t_num  v_total;
        rhc_pkg::t_num  v_six_d;
        logic           v_grey;
        logic [LPW-1:0] v_lprod;
        v_sum   = rhc_pkg::t_sum'(r_hi1) + rhc_pkg::t_sum'(r_lo1);
        v_d     = r_hi1 - r_lo1;
        v_grey  = (r_hi1 == r_lo1);
        v_den   = (v_sum > rhc_pkg::t_sum'(rhc_pkg::CH_MAX)) ?
                  (rhc_pkg::SUM_MAX - v_sum) : v_sum;
        // The signed numerator never drives the total below zero.
        v_total = rhc_pkg::t_num'(rhc_pkg::t_num'(r_off1) * rhc_pkg::t_num'(v_d))
                + {{(rhc_pkg::NUM_W - rhc_pkg::CH_W - 1){r_num1[rhc_pkg::CH_W]}}, r_num1};
        v_six_d = rhc_pkg::t_num'(rhc_pkg::HUE_SECTORS * rhc_pkg::t_num'(v_d));
        v_lprod = LPW'(v_sum) * LPW'(LIGHT_MUL);

        // A grey pixel divides zero by one, which yields zero hue and saturation.
        n_op2[rhc_pkg::LANE_HUE].num   = v_grey ? '0 : v_total;
        n_op2[rhc_pkg::LANE_HUE].den   = v_grey ? rhc_pkg::t_den'(1) : rhc_pkg::t_den'(v_six_d);
        n_op2[rhc_pkg::LANE_SAT].num   = v_grey ? '0 : rhc_pkg::t_num'(v_d);
        n_op2[rhc_pkg::LANE_SAT].den   = v_grey ? rhc_pkg::t_den'(1) : rhc_pkg::t_den'(v_den);
        n_light2 = v_lprod[rhc_pkg::LIGHT_SHIFT +: FRACTION_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_pix.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_hi1  <= n_hi1;
            r_lo1  <= n_lo1;
            r_num1 <= n_num1;
            r_off1 <= n_off1;
        end
        if (w_en2) begin
            r_op2    <= n_op2;
            r_light2 <= n_light2;
        end
    end

    rhc_divpipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divpipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (w_div_ready),
        .i_ops   (r_op2),
        .i_side  (r_light2),
        .o_valid (w_div_valid),
        .i_ready (o_hsl.ready),
        .o_quot  (w_quot),
        .o_side  (w_light)
    );

    assign o_hsl.valid           = w_div_valid;
    assign o_hsl.data.hue        = rhc_pkg::t_field'(w_quot[rhc_pkg::LANE_HUE]);
    assign o_hsl.data.saturation = rhc_pkg::t_field'(w_quot[rhc_pkg::LANE_SAT]);
    assign o_hsl.data.lightness  = rhc_pkg::t_field'(w_light);

    `RHC_ASSERT_IMPLIES(a_hue_below_turn, i_clk, i_rst_n, r_v2, r_op2[rhc_pkg::LANE_HUE].num < r_op2[rhc_pkg::LANE_HUE].den, "hue numerator reached a full turn")

    `RHC_ASSERT_IMPLIES(a_sat_at_most_one, i_clk, i_rst_n, r_v2, r_op2[rhc_pkg::LANE_SAT].num <= r_op2[rhc_pkg::LANE_SAT].den && r_op2[rhc_pkg::LANE_SAT].den != '0, "saturation operands out of range")

    `RHC_ASSERT_IMPLIES(a_front_full_when_blocked, i_clk, i_rst_n, !i_pix.ready, r_v1 && r_v2 && !w_div_ready, "input refused while a front stage was free")

endmodule
